[hw/rtl/scsa_pkg.sv]
// shared types and codes for the size class slab allocator
// no dependencies
package scsa_pkg;

    localparam int ADDR_W      = 18;
    localparam int SIZE_W      = 12;
    localparam int NUM_CLASSES = 7;
    localparam int CLS_W       = 3;
    localparam int MAX_SMALL   = 1024;
    localparam int GRANULE_SH  = 4;

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_kind_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_PAGE   = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_BAD_PTR   = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] result_addr;
    } resp_t;

endpackage

[hw/rtl/size_class_slab_allocator.sv]
// size class slab allocator: alloc pops a class list, free pushes a page list
// an alloc pops a nonempty class list, else splices the idle page of its class, else scans
// the in-use bits for the lowest unused page, links its blocks in turn (up to
// (PAGE_BYTES-HEADER_BYTES)/16) and closes the page record; oversize gets ST_TOO_LARGE
// throughput: one transaction at a time, the next is taken in the cycle after the result
// register loads; reset clears in-use bits, class heads and idle pages, memories need no sweep
module size_class_slab_allocator
    import scsa_pkg::*;
#(
    parameter int NUM_PAGES    = 64,
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 32
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  req_t  s_data,
    output logic  m_valid,
    input  logic  m_ready,
    output resp_t m_data
);

    // derived sizes
    localparam int PG_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int PG_SH     = $clog2(PAGE_BYTES);
    localparam int OFF_W     = PG_SH + 1;
    localparam int CNT_W     = $clog2(PAGE_BYTES / 16 + 1);
    localparam int LINK_FULL = NUM_PAGES * (PAGE_BYTES / 16);
    localparam int LINK_MAX  = 1 << (ADDR_W - GRANULE_SH);
    localparam int LD        = (LINK_FULL < LINK_MAX) ? LINK_FULL : LINK_MAX;
    localparam int LI_W      = $clog2(LD);

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [CNT_W-1:0]  avail;
        logic [CNT_W-1:0]  total;
        logic [ADDR_W-1:0] head;
        logic [ADDR_W-1:0] tail;
    } page_rec_t;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_DECODE    = 10'b00_0000_0010,
        S_SCAN      = 10'b00_0000_0100,
        S_CARVE     = 10'b00_0000_1000,
        S_SPLICE_RD = 10'b00_0001_0000,
        S_SPLICE    = 10'b00_0010_0000,
        S_POP_RD    = 10'b00_0100_0000,
        S_POP       = 10'b00_1000_0000,
        S_FREE_CHK  = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } state_t;

    // granule index into link memory, out of range folds to entry zero
    function automatic logic [LI_W-1:0] link_idx(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-GRANULE_SH-1:0] g;
        g = a[ADDR_W-1:GRANULE_SH];
        return (32'(g) < LD) ? g[LI_W-1:0] : '0;
    endfunction

    function automatic logic [OFF_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
        return OFF_W'(16) << c;
    endfunction

    // first block offset: header rounded up to the block size
    function automatic logic [OFF_W-1:0] first_off(input logic [CLS_W-1:0] c);
        logic [OFF_W-1:0] b;
        b = class_bytes(c);
        return (OFF_W'(HEADER_BYTES) + b - OFF_W'(1)) & ~(b - OFF_W'(1));
    endfunction

    // state registers
    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [CLS_W-1:0]   cls_reg, cls_next;
    logic [PG_W-1:0]    pg_reg, pg_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [ADDR_W-1:0]  prev_reg, prev_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [1:0]         status_reg, status_next;
    logic [ADDR_W-1:0]  result_reg, result_next;
    logic               m_valid_reg, m_valid_next;
    resp_t              m_data_reg, m_data_next;

    // allocator bookkeeping held in flops
    logic [NUM_PAGES-1:0]  in_use_reg, in_use_next;
    logic [ADDR_W-1:0]     class_head_reg [NUM_CLASSES];
    logic [ADDR_W-1:0]     class_head_next [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] idle_valid_reg, idle_valid_next;
    logic [PG_W-1:0]       idle_page_reg [NUM_CLASSES];
    logic [PG_W-1:0]       idle_page_next [NUM_CLASSES];

    // link memory port
    logic              link_we;
    logic [LI_W-1:0]   link_waddr, link_raddr;
    logic [ADDR_W-1:0] link_wdata, link_q;

    // per-page record memory
    page_rec_t         page_mem [NUM_PAGES];
    logic              page_we;
    logic [PG_W-1:0]   page_waddr, page_raddr;
    page_rec_t         page_wdata, page_q;

    scsa_link_ram #(
        .DEPTH (LD),
        .AW    (LI_W),
        .DW    (ADDR_W)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_q)
    );

    always_ff @(posedge aclk) begin
        if (page_we) begin
            page_mem[page_waddr] <= page_wdata;
        end
        page_q <= page_mem[page_raddr];
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // datapath helpers
    logic [CLS_W-1:0]  size_cls;
    logic [31:0]       free_pg_wide;
    logic [PG_W-1:0]   free_pg;
    logic [31:0]       base_wide;
    logic [ADDR_W-1:0] page_base;
    logic [ADDR_W-1:0] carve_addr;
    logic [OFF_W-1:0]  blk_bytes;
    logic [CLS_W-1:0]  rec_cls;
    logic [OFF_W-1:0]  rec_bytes;
    logic [OFF_W-1:0]  free_off;
    logic [ADDR_W-1:0] splice_head;
    logic [CNT_W-1:0]  avail_inc;

    always_comb begin
        // smallest class that holds the request, capped at the largest
        size_cls = CLS_W'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if ((32'(16) << i) >= 32'(req_reg.req_size)) begin
                size_cls = CLS_W'(i);
            end
        end
        free_pg_wide = 32'(req_reg.block_addr) >> PG_SH;
        free_pg      = free_pg_wide[PG_W-1:0];
        base_wide    = 32'(pg_reg) << PG_SH;
        page_base    = base_wide[ADDR_W-1:0];
        carve_addr   = page_base + ADDR_W'(off_reg);
        blk_bytes    = class_bytes(cls_reg);
        rec_cls      = (page_q.cls == CLS_W'(NUM_CLASSES)) ? '0 : page_q.cls;
        rec_bytes    = class_bytes(rec_cls);
        free_off     = OFF_W'(req_reg.block_addr & ADDR_W'(PAGE_BYTES - 1));
        splice_head  = (page_q.head != '0) ? page_q.head : class_head_reg[cls_reg];
        avail_inc    = page_q.avail + CNT_W'(1);
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        cls_next        = cls_reg;
        pg_next         = pg_reg;
        off_next        = off_reg;
        prev_next       = prev_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        status_next     = status_reg;
        result_next     = result_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        in_use_next     = in_use_reg;
        class_head_next = class_head_reg;
        idle_valid_next = idle_valid_reg;
        idle_page_next  = idle_page_reg;

        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_raddr = link_idx(head_reg);
        page_we    = 1'b0;
        page_waddr = pg_reg;
        page_wdata = page_q;
        page_raddr = pg_reg;

        // result register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_data;
                    status_next = ST_OK;
                    result_next = '0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE: begin
                if (req_reg.req_type == REQ_ALLOC) begin
                    cls_next = size_cls;
                    if (32'(req_reg.req_size) > MAX_SMALL) begin
                        status_next = ST_TOO_LARGE;
                        state_next  = S_DONE;
                    end else if (class_head_reg[size_cls] != '0) begin
                        head_next  = class_head_reg[size_cls];
                        state_next = S_POP_RD;
                    end else if (idle_valid_reg[size_cls]) begin
                        pg_next    = idle_page_reg[size_cls];
                        state_next = S_SPLICE_RD;
                    end else begin
                        pg_next    = '0;
                        state_next = S_SCAN;
                    end
                end else begin
                    // null free is a no-op
                    if (req_reg.block_addr == '0) begin
                        state_next = S_DONE;
                    end else if (free_pg_wide >= 32'(NUM_PAGES) || !in_use_reg[free_pg]) begin
                        status_next = ST_BAD_PTR;
                        state_next  = S_DONE;
                    end else begin
                        pg_next    = free_pg;
                        page_raddr = free_pg;
                        state_next = S_FREE_CHK;
                    end
                end
            end

            // walk the in-use bits for the lowest unused page
            S_SCAN: begin
                if (!in_use_reg[pg_reg]) begin
                    off_next   = first_off(cls_reg);
                    prev_next  = '0;
                    cnt_next   = '0;
                    state_next = S_CARVE;
                end else if (32'(pg_reg) == NUM_PAGES - 1) begin
                    status_next = ST_NO_PAGE;
                    state_next  = S_DONE;
                end else begin
                    pg_next = pg_reg + PG_W'(1);
                end
            end

            // one block linked per cycle, list ends up highest address first
            S_CARVE: begin
                if (32'(off_reg) + 32'(blk_bytes) <= PAGE_BYTES) begin
                    link_we    = 1'b1;
                    link_waddr = link_idx(carve_addr);
                    link_wdata = prev_reg;
                    prev_next  = carve_addr;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    off_next   = off_reg + blk_bytes;
                end else begin
                    page_we          = 1'b1;
                    page_wdata.cls   = cls_reg;
                    page_wdata.avail = cnt_reg;
                    page_wdata.total = cnt_reg;
                    page_wdata.head  = prev_reg;
                    page_wdata.tail  = (cnt_reg != '0)
                                     ? page_base + ADDR_W'(first_off(cls_reg)) : '0;
                    in_use_next[pg_reg]     = 1'b1;
                    idle_page_next[cls_reg] = pg_reg;
                    state_next              = S_SPLICE_RD;
                end
            end

            S_SPLICE_RD: begin
                page_raddr = pg_reg;
                state_next = S_SPLICE;
            end

            // hand the whole page list over to the class list
            S_SPLICE: begin
                if (page_q.tail != '0) begin
                    link_we    = 1'b1;
                    link_waddr = link_idx(page_q.tail);
                    link_wdata = class_head_reg[cls_reg];
                end
                class_head_next[cls_reg] = splice_head;
                page_we          = 1'b1;
                page_wdata       = page_q;
                page_wdata.avail = '0;
                page_wdata.head  = '0;
                page_wdata.tail  = '0;
                idle_valid_next[cls_reg] = 1'b0;
                if (splice_head == '0) begin
                    status_next = ST_NO_PAGE;
                    state_next  = S_DONE;
                end else begin
                    head_next  = splice_head;
                    state_next = S_POP_RD;
                end
            end

            S_POP_RD: begin
                link_raddr = link_idx(head_reg);
                state_next = S_POP;
            end

            S_POP: begin
                class_head_next[cls_reg] = link_q;
                result_next = head_reg;
                status_next = ST_OK;
                state_next  = S_DONE;
            end

            // validate pointer against its page, then push onto the page list
            S_FREE_CHK: begin
                if ((free_off & (rec_bytes - OFF_W'(1))) != '0
                    || free_off < first_off(rec_cls)
                    || 32'(free_off) + 32'(rec_bytes) > PAGE_BYTES
                    || page_q.avail >= page_q.total) begin
                    status_next = ST_BAD_PTR;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = link_idx(req_reg.block_addr);
                    link_wdata = page_q.head;
                    page_we          = 1'b1;
                    page_wdata       = page_q;
                    page_wdata.avail = avail_inc;
                    page_wdata.head  = req_reg.block_addr;
                    if (page_q.head == '0) begin
                        page_wdata.tail = req_reg.block_addr;
                    end
                    if (avail_inc == page_q.total) begin
                        if (idle_valid_reg[rec_cls]) begin
                            in_use_next[pg_reg] = 1'b0;
                        end else begin
                            idle_valid_next[rec_cls] = 1'b1;
                            idle_page_next[rec_cls]  = pg_reg;
                        end
                    end
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = status_reg;
                    m_data_next.result_addr = result_reg;
                    state_next              = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            in_use_reg     <= '0;
            idle_valid_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                class_head_reg[i] <= '0;
                idle_page_reg[i]  <= '0;
            end
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            in_use_reg     <= in_use_next;
            idle_valid_reg <= idle_valid_next;
            class_head_reg <= class_head_next;
            idle_page_reg  <= idle_page_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        cls_reg    <= cls_next;
        pg_reg     <= pg_next;
        off_reg    <= off_next;
        prev_reg   <= prev_next;
        cnt_reg    <= cnt_next;
        head_reg   <= head_next;
        status_reg <= status_next;
        result_reg <= result_next;
        m_data_reg <= m_data_next;
    end

endmodule

[hw/rtl/scsa_link_ram.sv]
// single port write, single port read memory for the free list links
// depends on nothing
module scsa_link_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 18
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
